>>> rtl/core/fhcp_pkg.sv
// Shared types and constants for the fan / heater command parser.
// No dependencies; compiled before the interfaces and modules.
package fhcp_pkg;

  // Default sizing of the controlled hardware
  localparam int unsigned FanCountDef    = 3;
  localparam int unsigned HeaterCountDef = 2;
  localparam int unsigned SensorCountDef = 2;
  localparam int unsigned LevelDigitsDef = 4;

  localparam int unsigned LevelW   = 14;
  localparam int unsigned ReplyMax = 6;
  localparam int unsigned LenW     = 3;

  localparam logic [LevelW-1:0] ResetLevel    = 14'd1023;
  localparam logic [15:0]       ResetLevelBcd = 16'h1023;

  // ASCII codes used by the command syntax and the replies
  localparam logic [7:0] CH_HASH = 8'h23;  // '#'
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [3:0] DIGIT_HI = 4'h3;  // upper nibble of '0'..'9'

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       sensor_index;
    logic [7:0] sensor_value;
  } in_item_t;

  // One reply: characters go out from index 0 upward
  typedef struct packed {
    logic [ReplyMax-1:0][7:0] chars;
    logic [LenW-1:0]          len;
    logic [2:0]               fan_bits;
    logic [LevelW-1:0]        heater1;
    logic [LevelW-1:0]        heater2;
  } reply_t;

endpackage

>>> rtl/core/fhcp_if.sv
// Valid/ready channel interfaces for the command parser input and reply words.
// Depends on nothing; modules see them through source and sink modports.
interface fhcp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  logic       sensor_index;
  logic [7:0] sensor_value;

  modport source (output valid, func, rx_byte, sensor_index, sensor_value, input ready);
  modport sink   (input valid, func, rx_byte, sensor_index, sensor_value, output ready);
endinterface

interface fhcp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        last_char;
  logic [2:0]  fan_bits;
  logic [13:0] heater1_compare;
  logic [13:0] heater2_compare;

  modport source (output valid, out_char, last_char, fan_bits, heater1_compare,
                  heater2_compare, input ready);
  modport sink   (input valid, out_char, last_char, fan_bits, heater1_compare,
                  heater2_compare, output ready);
endinterface

>>> rtl/core/fhcp_parser.sv
// Command parser state machine and device state (fans, heater levels, temperatures).
// Builds the whole reply for one word combinationally. Uses fhcp_pkg.
module fhcp_parser import fhcp_pkg::*; #(
  parameter int unsigned FAN_COUNT    = FanCountDef,
  parameter int unsigned HEATER_COUNT = HeaterCountDef,
  parameter int unsigned SENSOR_COUNT = SensorCountDef,
  parameter int unsigned LEVEL_DIGITS = LevelDigitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_item_t item_i,
  output reply_t   reply_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD, PH_SET_KIND, PH_GET_KIND, PH_SF_UNIT, PH_SF_STATUS,
    PH_SP_UNIT, PH_SP_LEVEL, PH_GF_UNIT, PH_GP_UNIT, PH_GT_UNIT
  } phase_e;

  // 8-bit binary to three BCD digits
  function automatic logic [11:0] to_bcd3(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [6:0]  o;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = v - 8'd100;
    end else begin
      h = 2'd0;
      r = v;
    end
    prod = 15'(r) * 15'd205;  // r / 10 for r < 100
    t    = prod[14:11];
    o    = 7'(r) - 7'(t) * 7'd10;
    return {2'b00, h, t, o[3:0]};
  endfunction

  phase_e            phase_q, phase_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [LevelW-1:0] acc_q, acc_d;
  logic [15:0]       bcd_q, bcd_d;
  logic [3:0]        unit_q, unit_d;
  logic [FAN_COUNT-1:0] fan_q, fan_d;
  logic [LevelW-1:0] lvl_q [HEATER_COUNT];
  logic [LevelW-1:0] lvl_d [HEATER_COUNT];
  logic [15:0]       lvl_bcd_q [HEATER_COUNT];
  logic [15:0]       lvl_bcd_d [HEATER_COUNT];
  logic [11:0]       temp_q [SENSOR_COUNT];
  logic [11:0]       temp_d [SENSOR_COUNT];

  logic [7:0]        c;
  logic              is_dig;
  logic [3:0]        d;
  logic              fan_sel;
  logic [15:0]       lvl_sel;
  logic [11:0]       temp_sel;
  logic [LevelW-1:0] acc_n;
  logic [2:0]        cnt_n;
  logic [ReplyMax-1:0][7:0] chars;
  logic [LenW-1:0]   len;
  logic [7:0]        fan_pad;
  logic [7:0][LevelW-1:0] lvl_pad;

  assign c      = item_i.rx_byte;
  assign is_dig = c inside {[8'h30:8'h39]};
  assign d      = is_dig ? c[3:0] : 4'd0;
  assign acc_n  = 14'((acc_q << 3) + (acc_q << 1)) + 14'(d);
  assign cnt_n  = cnt_q + 3'd1;

  // Lookups by the unit digit; unknown units read as zero
  always_comb begin
    fan_sel  = 1'b0;
    lvl_sel  = '0;
    temp_sel = '0;
    for (int i = 0; i < FAN_COUNT; i++)
      if (int'(d) == i + 1) fan_sel = fan_q[i];
    for (int i = 0; i < HEATER_COUNT; i++)
      if (int'(d) == i + 1) lvl_sel = lvl_bcd_q[i];
    for (int i = 0; i < SENSOR_COUNT; i++)
      if (int'(d) == i + 1) temp_sel = temp_q[i];
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    bcd_d     = bcd_q;
    unit_d    = unit_q;
    fan_d     = fan_q;
    lvl_d     = lvl_q;
    lvl_bcd_d = lvl_bcd_q;
    temp_d    = temp_q;
    chars     = '0;
    len       = '0;

    if (item_i.func) begin
      for (int i = 0; i < SENSOR_COUNT; i++)
        if (int'(item_i.sensor_index) == i) temp_d[i] = to_bcd3(item_i.sensor_value);
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (c == CH_HASH) begin
            phase_d = PH_CMD;
          end else begin
            chars[0] = CH_N; chars[1] = CH_O; len = 3'd2;
          end
        end
        PH_CMD: begin
          if (c == CH_S) begin
            phase_d = PH_SET_KIND;
          end else if (c == CH_G) begin
            phase_d = PH_GET_KIND;
          end else begin
            phase_d = PH_IDLE;
            chars[0] = CH_N; chars[1] = CH_O; len = 3'd2;
          end
        end
        PH_SET_KIND: begin
          if (c == CH_F) begin
            phase_d = PH_SF_UNIT;
          end else if (c == CH_P) begin
            phase_d = PH_SP_UNIT;
          end else begin
            phase_d = PH_IDLE;
            chars[0] = CH_N; chars[1] = CH_O; len = 3'd2;
          end
        end
        PH_GET_KIND: begin
          if (c == CH_F) begin
            phase_d = PH_GF_UNIT;
          end else if (c == CH_P) begin
            phase_d = PH_GP_UNIT;
          end else if (c == CH_T) begin
            phase_d = PH_GT_UNIT;
          end else begin
            phase_d = PH_IDLE;
            chars[0] = CH_N; chars[1] = CH_O; len = 3'd2;
          end
        end
        default: begin
          // digit positions: a non-digit is refused and skipped
          if (!is_dig) begin
            chars[0] = CH_N; chars[1] = CH_O; len = 3'd2;
          end else begin
            case (phase_q)
              PH_SF_UNIT: begin
                unit_d  = d;
                phase_d = PH_SF_STATUS;
              end
              PH_SF_STATUS: begin
                for (int i = 0; i < FAN_COUNT; i++)
                  if (int'(unit_q) == i + 1) fan_d[i] = (d != 4'd0);
                phase_d = PH_IDLE;
                chars[0] = CH_O; chars[1] = CH_K; len = 3'd2;
              end
              PH_SP_UNIT: begin
                unit_d  = d;
                cnt_d   = '0;
                acc_d   = '0;
                bcd_d   = '0;
                phase_d = PH_SP_LEVEL;
              end
              PH_SP_LEVEL: begin
                if (cnt_n >= 3'(LEVEL_DIGITS)) begin
                  for (int i = 0; i < HEATER_COUNT; i++) begin
                    if (int'(unit_q) == i + 1) begin
                      lvl_d[i]     = acc_n;
                      lvl_bcd_d[i] = {bcd_q[11:0], d};
                    end
                  end
                  cnt_d   = '0;
                  acc_d   = '0;
                  bcd_d   = '0;
                  phase_d = PH_IDLE;
                  chars[0] = CH_O; chars[1] = CH_K; len = 3'd2;
                end else begin
                  cnt_d = cnt_n;
                  acc_d = acc_n;
                  bcd_d = {bcd_q[11:0], d};
                end
              end
              PH_GF_UNIT: begin
                chars[0] = CH_F;
                chars[1] = {DIGIT_HI, d};
                chars[2] = {DIGIT_HI, 3'b000, fan_sel};
                len      = 3'd3;
                phase_d  = PH_IDLE;
              end
              PH_GP_UNIT: begin
                chars[0] = CH_P;
                chars[1] = {DIGIT_HI, d};
                chars[2] = {DIGIT_HI, lvl_sel[15:12]};
                chars[3] = {DIGIT_HI, lvl_sel[11:8]};
                chars[4] = {DIGIT_HI, lvl_sel[7:4]};
                chars[5] = {DIGIT_HI, lvl_sel[3:0]};
                len      = 3'd6;
                phase_d  = PH_IDLE;
              end
              default: begin  // temperature read
                chars[0] = CH_T;
                chars[1] = {DIGIT_HI, d};
                chars[2] = {DIGIT_HI, temp_sel[11:8]};
                chars[3] = {DIGIT_HI, temp_sel[7:4]};
                chars[4] = {DIGIT_HI, temp_sel[3:0]};
                len      = 3'd5;
                phase_d  = PH_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end

  // Status reflects the state after this word
  always_comb begin
    fan_pad = '0;
    fan_pad[FAN_COUNT-1:0] = fan_d;
    lvl_pad = '0;
    for (int i = 0; i < HEATER_COUNT; i++) lvl_pad[i] = lvl_d[i];
  end

  assign reply_o.chars    = chars;
  assign reply_o.len      = len;
  assign reply_o.fan_bits = fan_pad[2:0];
  assign reply_o.heater1  = lvl_pad[0];
  assign reply_o.heater2  = lvl_pad[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      bcd_q   <= '0;
      unit_q  <= '0;
      for (int i = 0; i < FAN_COUNT; i++) fan_q[i] <= (i == 1);
      for (int i = 0; i < HEATER_COUNT; i++) begin
        lvl_q[i]     <= ResetLevel;
        lvl_bcd_q[i] <= ResetLevelBcd;
      end
      for (int i = 0; i < SENSOR_COUNT; i++) temp_q[i] <= '0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      acc_q     <= acc_d;
      bcd_q     <= bcd_d;
      unit_q    <= unit_d;
      fan_q     <= fan_d;
      lvl_q     <= lvl_d;
      lvl_bcd_q <= lvl_bcd_d;
      temp_q    <= temp_d;
    end
  end

endmodule

>>> rtl/core/ascii_fan_heater_command_parser_top.sv
// Fan / heater command parser: top level with input register and reply buffer.
// Uses fhcp_pkg, fhcp_in_if, fhcp_out_if and fhcp_parser.
//
// in_i carries one word per handshake: a received serial byte (func = 0) or
// an ADC temperature sample (func = 1). out_o carries one reply character per
// word, with last_char on the final character and the fan and heater status
// as it stands after the command that caused the reply.
// A word is registered on acceptance; once the reply buffer is free the parser
// consumes it and loads the complete reply (0 to 6 characters) into a shift
// buffer, from whose register the first character is offered.
// Throughput: a word whose reply has characters holds the parser until its last
// character is taken at the single-character output port; words without a
// reply (samples, partial commands) go at one per cycle while the buffer is
// empty. The parser takes the next word in the same cycle as the last reply
// character is taken. When the receiver stalls, the buffer holds and the input
// side stops once its register is full. Reset returns the parser to idle, turns
// only fan 2 on, sets both heater levels to 1023 and clears the temperatures.
module ascii_fan_heater_command_parser_top import fhcp_pkg::*; #(
  parameter int unsigned FAN_COUNT    = FanCountDef,
  parameter int unsigned HEATER_COUNT = HeaterCountDef,
  parameter int unsigned SENSOR_COUNT = SensorCountDef,
  parameter int unsigned LEVEL_DIGITS = LevelDigitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  fhcp_in_if.sink    in_i,
  fhcp_out_if.source out_o
);

  logic     in_vld_q;
  in_item_t item_q;
  logic     buf_free;
  logic     take;
  reply_t   reply;

  logic [ReplyMax-1:0][7:0] chars_q;
  logic [LenW-1:0]          cnt_q;
  logic [2:0]               fan_q;
  logic [LevelW-1:0]        h1_q;
  logic [LevelW-1:0]        h2_q;

  // buffer may be reloaded once its last character leaves
  assign buf_free   = (cnt_q == '0) || (cnt_q == 3'd1 && out_o.ready);
  assign take       = in_vld_q && buf_free;
  assign in_i.ready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.func         <= in_i.func;
      item_q.rx_byte      <= in_i.rx_byte;
      item_q.sensor_index <= in_i.sensor_index;
      item_q.sensor_value <= in_i.sensor_value;
    end
  end

  fhcp_parser #(
    .FAN_COUNT    (FAN_COUNT),
    .HEATER_COUNT (HEATER_COUNT),
    .SENSOR_COUNT (SENSOR_COUNT),
    .LEVEL_DIGITS (LEVEL_DIGITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (item_q),
    .reply_o (reply)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (take) begin
      cnt_q <= reply.len;
    end else if (out_o.valid && out_o.ready) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      chars_q <= reply.chars;
      fan_q   <= reply.fan_bits;
      h1_q    <= reply.heater1;
      h2_q    <= reply.heater2;
    end else if (out_o.valid && out_o.ready) begin
      chars_q <= {8'h00, chars_q[ReplyMax-1:1]};
    end
  end

  assign out_o.valid           = (cnt_q != '0);
  assign out_o.out_char        = chars_q[0];
  assign out_o.last_char       = (cnt_q == 3'd1);
  assign out_o.fan_bits        = fan_q;
  assign out_o.heater1_compare = h1_q;
  assign out_o.heater2_compare = h2_q;

  // reply lengths stay within the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (reply.len <= 3'(ReplyMax)))
    else $error("reply longer than buffer");

  // a loaded reply with characters is offered on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && reply.len != '0) |=> out_o.valid)
    else $error("reply lost after load");

  // a held input word is not overwritten before the parser takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !take) |=> (in_vld_q && $stable(item_q)))
    else $error("pending word dropped");

  // the parser never reloads while more than one character is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (cnt_q <= 3'd1))
    else $error("reply buffer overrun");

endmodule
